// ===== rtl/mqpjs_pkg.sv =====
package mqpjs_pkg;

  typedef enum logic [2:0] {
    KIND_PUT    = 3'd0,
    KIND_GET    = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_ABORT  = 3'd3,
    KIND_DISC   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    RES_OK   = 2'd0,
    RES_NONE = 2'd1,
    RES_FULL = 2'd2
  } res_e;

  typedef enum logic [1:0] {
    ST_FREE   = 2'd0,
    ST_QUEUED = 2'd1,
    ST_BUSY   = 2'd2
  } slot_e;

endpackage

// ===== rtl/mqpjs_ram.sv =====
module mqpjs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/multi_queue_priority_job_scheduler_unit.sv =====
// Multi-queue priority job scheduler.
// One request enters on the in channel (kind_i, client_i, target_queue_i,
// queue_mask_i, job_priority_i, job_number_i) and gives exactly one result
// beat on the out channel (status_o, out_job_o, out_priority_o, out_queue_o).
// The job table lives in a RAM and is walked by one sequencer with a single
// shared compare unit, one slot per cycle. A request walks every slot over
// the RAM read port, then passes through a write state for the slot write,
// whatever the request. in_ready_o is high only while the block is idle, so
// a new request is taken at the earliest in the cycle after the result beat
// is taken.
// Slot states sit in flip-flops that reset clears to free; the other slot
// fields are written before they are read. After reset the id counter is one.
// While the receiver stalls the result stays unchanged and no new request is
// taken.
module multi_queue_priority_job_scheduler_unit
  import mqpjs_pkg::*;
#(
  parameter int QUEUE_COUNT  = 16,
  parameter int JOB_SLOTS    = 64,
  parameter int CLIENT_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [2:0]  client_i,
  input  logic [3:0]  target_queue_i,
  input  logic [15:0] queue_mask_i,
  input  logic [31:0] job_priority_i,
  input  logic [31:0] job_number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] out_job_o,
  output logic [31:0] out_priority_o,
  output logic [3:0]  out_queue_o
);

  localparam int AW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam int CW = $clog2(JOB_SLOTS + 1);
  localparam int DW = 32 + 32 + 4 + 3;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_OUT   = 4'b1000
  } fsm_e;

  fsm_e state_q, state_d;
  logic [1:0] st_q [JOB_SLOTS];
  logic [31:0] idc_q;

  logic [2:0]  kind_q;
  logic [2:0]  cli_q;
  logic [3:0]  tq_q;
  logic [15:0] mask_q;
  logic [31:0] prio_q, num_q;

  logic [CW-1:0] rcnt_q;  // read address issued
  logic [CW-1:0] ccnt_q;  // slot whose data is compared
  logic          rv_q;    // read data valid

  logic          best_v_q, busy_v_q, free_v_q;
  logic [AW-1:0] best_q, busy_q, free_q;
  logic [31:0]   bprio_q, bid_q, busyid_q;
  logic [3:0]    bq_q;

  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata, rdata;
  logic [31:0]   r_id, r_prio;
  logic [3:0]    r_q;
  logic [2:0]    r_own;

  logic [1:0]  status_q;
  logic [31:0] ojob_q, oprio_q;
  logic [3:0]  oq_q;
  logic        ov_q;

  mqpjs_ram #(.Width(DW), .Depth(JOB_SLOTS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(rcnt_q[AW-1:0]),
    .rdata_o(rdata)
  );

  assign {r_id, r_prio, r_q, r_own} = rdata;

  logic          cl_ok;
  logic [AW-1:0] ci;
  logic [1:0]    cst;
  logic          c_cand, c_better, c_busy, c_free;
  logic          c_match;

  assign cl_ok = 32'(cli_q) < 32'(CLIENT_COUNT);
  assign ci    = ccnt_q[AW-1:0];
  assign cst   = st_q[ci];

  // The one compare unit: priority, then queue, then id.
  always_comb begin
    c_cand  = (cst == ST_QUEUED) && (32'(r_q) < 32'(QUEUE_COUNT)) && mask_q[r_q];
    c_better = !best_v_q || (r_prio > bprio_q) ||
               ((r_prio == bprio_q) && ((r_q < bq_q) ||
                ((r_q == bq_q) && (r_id < bid_q))));
    c_busy  = (cst == ST_BUSY) && (r_own == cli_q);
    c_free  = (cst != ST_QUEUED) && (cst != ST_BUSY);
    c_match = ((cst == ST_QUEUED) || (cst == ST_BUSY)) && (r_id == num_q);
  end

  logic put_ok, q_ok, get_ok;
  assign q_ok   = 32'(tq_q) < 32'(QUEUE_COUNT);
  assign put_ok = (kind_q == KIND_PUT) && cl_ok && q_ok && free_v_q;
  assign get_ok = (kind_q == KIND_GET) && cl_ok && best_v_q;

  // Result and slot write, decided once the walk is over.
  logic [1:0]  res_st;
  logic [31:0] res_job, res_prio;
  logic [3:0]  res_q;
  always_comb begin
    res_st = RES_NONE; res_job = '0; res_prio = '0; res_q = '0;
    if (cl_ok) begin
      unique case (kind_q)
        KIND_PUT: begin
          if (q_ok) begin
            if (!free_v_q) res_st = RES_FULL;
            else begin res_st = RES_OK; res_job = idc_q; end
          end
        end
        KIND_GET: begin
          if (best_v_q) begin
            res_st = RES_OK; res_job = bid_q; res_prio = bprio_q; res_q = bq_q;
          end
        end
        KIND_DELETE: if (best_v_q) res_st = RES_OK;
        KIND_ABORT:  if (busy_v_q && busyid_q == num_q) res_st = RES_OK;
        KIND_DISC:   if (busy_v_q) res_st = RES_OK;
        default: ;
      endcase
    end
  end

  // A get rewrites the claimed slot with its new owner; a put fills a free slot.
  assign we    = (state_q == S_WRITE) && (put_ok || get_ok);
  assign waddr = get_ok ? best_q : free_q;
  assign wdata = get_ok ? {bid_q, bprio_q, bq_q, cli_q} : {idc_q, prio_q, tq_q, 3'd0};

  logic scan_end;
  assign scan_end = rv_q && (ccnt_q == CW'(JOB_SLOTS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_SCAN;
      S_SCAN:  if (scan_end) state_d = S_WRITE;
      S_WRITE: state_d = S_OUT;
      S_OUT:   if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idc_q   <= 32'd1;
      rcnt_q  <= '0;
      ccnt_q  <= '0;
      rv_q    <= 1'b0;
      ov_q    <= 1'b0;
      for (int i = 0; i < JOB_SLOTS; i++) st_q[i] <= ST_FREE;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          rcnt_q <= '0;
          ccnt_q <= '0;
          rv_q   <= 1'b0;
          if (in_valid_i) begin
            rv_q   <= 1'b1;  // address zero is read this cycle
            rcnt_q <= CW'(1);
          end
        end
        S_SCAN: begin
          if (rcnt_q < CW'(JOB_SLOTS - 1)) rcnt_q <= rcnt_q + CW'(1);
          if (rv_q) ccnt_q <= ccnt_q + CW'(1);
        end
        S_WRITE: begin
          ov_q   <= 1'b1;
          rcnt_q <= '0;
          if (cl_ok) begin
            unique case (kind_q)
              KIND_PUT: if (put_ok) begin
                st_q[free_q] <= ST_QUEUED;
                idc_q <= idc_q + 32'd1;
              end
              KIND_GET: if (best_v_q) begin
                if (busy_v_q) st_q[busy_q] <= ST_FREE;
                st_q[best_q] <= ST_BUSY;
              end
              KIND_DELETE: if (best_v_q) st_q[best_q] <= ST_FREE;
              KIND_ABORT: if (busy_v_q && busyid_q == num_q) st_q[busy_q] <= ST_QUEUED;
              KIND_DISC:  if (busy_v_q) st_q[busy_q] <= ST_QUEUED;
              default: ;
            endcase
          end
        end
        S_OUT: if (out_ready_i) ov_q <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      kind_q <= kind_i; cli_q <= client_i; tq_q <= target_queue_i;
      mask_q <= queue_mask_i; prio_q <= job_priority_i; num_q <= job_number_i;
      best_v_q <= 1'b0; busy_v_q <= 1'b0; free_v_q <= 1'b0;
    end else if (state_q == S_SCAN && rv_q) begin
      if (kind_q == KIND_DELETE) begin
        if (c_match && !best_v_q) begin
          best_v_q <= 1'b1; best_q <= ci;
        end
      end else if (c_cand && c_better) begin
        best_v_q <= 1'b1; best_q <= ci;
        bprio_q <= r_prio; bid_q <= r_id; bq_q <= r_q;
      end
      if (c_busy && !busy_v_q) begin
        busy_v_q <= 1'b1; busy_q <= ci; busyid_q <= r_id;
      end
      if (c_free && !free_v_q) begin
        free_v_q <= 1'b1; free_q <= ci;
      end
    end
    if (state_q == S_WRITE) begin
      status_q <= res_st; ojob_q <= res_job; oprio_q <= res_prio; oq_q <= res_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign status_o       = status_q;
  assign out_job_o      = ojob_q;
  assign out_priority_o = oprio_q;
  assign out_queue_o    = oq_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped under stall");
  a_id_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idc_q != $past(idc_q) |-> idc_q == $past(idc_q) + 32'd1)
    else $error("id counter jumped");

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import mqpjs_pkg::*;

  localparam int SLOTS = 64;
  localparam int QUEUES = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 80;
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_MID = 3'd6;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] job;
    logic [31:0] prio;
    logic [3:0]  queue;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  kind_i = '0;
  logic [2:0]  client_i = '0;
  logic [3:0]  target_queue_i = '0;
  logic [15:0] queue_mask_i = '0;
  logic [31:0] job_priority_i = '0;
  logic [31:0] job_number_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] out_job_o;
  logic [31:0] out_priority_o;
  logic [3:0]  out_queue_o;

  multi_queue_priority_job_scheduler_unit u_dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the job table.
  slot_e       job_state [SLOTS];
  logic [31:0] job_id    [SLOTS];
  logic [31:0] job_prio  [SLOTS];
  logic [3:0]  job_queue [SLOTS];
  logic [2:0]  job_owner [SLOTS];
  logic [31:0] next_job_id;

  reply_t pending_replies[$];
  int     errors = 0;
  int     cycles = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic int owned_slot(input logic [2:0] client);
    for (int i = 0; i < SLOTS; i++)
      if (job_state[i] == ST_BUSY && job_owner[i] == client) return i;
    return -1;
  endfunction

  function automatic reply_t schedule_step(input logic [2:0] kind, input logic [2:0] client,
                                           input logic [3:0] tq, input logic [15:0] mask,
                                           input logic [31:0] prio, input logic [31:0] num);
    reply_t r;
    int     best;
    int     k;
    int     slot;
    r = '{status: RES_NONE, job: '0, prio: '0, queue: '0};
    best = -1;
    slot = -1;
    case (kind)
      KIND_PUT: begin
        for (int i = 0; i < SLOTS; i++)
          if (slot < 0 && job_state[i] == ST_FREE) slot = i;
        if (slot < 0) begin
          r.status = RES_FULL;
        end else begin
          job_state[slot] = ST_QUEUED;
          job_id[slot] = next_job_id;
          job_prio[slot] = prio;
          job_queue[slot] = tq;
          job_owner[slot] = '0;
          r.status = RES_OK;
          r.job = next_job_id;
          next_job_id++;
        end
      end
      KIND_GET: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (job_state[i] != ST_QUEUED || !mask[job_queue[i]]) continue;
          if (best < 0 || job_prio[i] > job_prio[best] ||
              (job_prio[i] == job_prio[best] &&
               (job_queue[i] < job_queue[best] ||
                (job_queue[i] == job_queue[best] && job_id[i] < job_id[best]))))
            best = i;
        end
        if (best >= 0) begin
          k = owned_slot(client);
          if (k >= 0) job_state[k] = ST_FREE;
          job_state[best] = ST_BUSY;
          job_owner[best] = client;
          r.status = RES_OK;
          r.job = job_id[best];
          r.prio = job_prio[best];
          r.queue = job_queue[best];
        end
      end
      KIND_DELETE: begin
        for (int i = 0; i < SLOTS; i++)
          if (slot < 0 && job_state[i] != ST_FREE && job_id[i] == num) slot = i;
        if (slot >= 0) begin
          job_state[slot] = ST_FREE;
          r.status = RES_OK;
        end
      end
      KIND_ABORT: begin
        k = owned_slot(client);
        if (k >= 0 && job_id[k] == num) begin
          job_state[k] = ST_QUEUED;
          r.status = RES_OK;
        end
      end
      KIND_DISC: begin
        k = owned_slot(client);
        if (k >= 0) begin
          job_state[k] = ST_QUEUED;
          r.status = RES_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(input logic [2:0] kind, input logic [2:0] client,
                              input logic [3:0] tq, input logic [15:0] mask,
                              input logic [31:0] prio, input logic [31:0] num);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    client_i <= client;
    target_queue_i <= tq;
    queue_mask_i <= mask;
    job_priority_i <= prio;
    job_number_i <= num;
    do @(posedge clk_i); while (!in_ready_o);
    pending_replies.push_back(schedule_step(kind, client, tq, mask, prio, num));
  endtask

  // Receiver side: random stalls, with long stretches of none.
  initial begin
    int hold;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 9) < 3) begin
        out_ready_i <= 1'b0;
        hold = pick_gap();
        repeat (hold) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 200)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    cycles <= cycles + 1;
    if (out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (out_job_o !== want.job)
          report_mismatch($sformatf("job %0d, expected %0d", out_job_o, want.job));
        if (out_priority_o !== want.prio)
          report_mismatch($sformatf("priority %h, expected %h", out_priority_o, want.prio));
        if (out_queue_o !== want.queue)
          report_mismatch($sformatf("queue %0d, expected %0d", out_queue_o, want.queue));
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [31:0] live_job_id();
    int tries;
    int s;
    for (tries = 0; tries < 8; tries++) begin
      s = $urandom_range(0, SLOTS - 1);
      if (job_state[s] != ST_FREE) return job_id[s];
    end
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_priority();
    case ($urandom_range(0, 5))
      0: return 32'hffff_ffff;
      1: return '0;
      2: return $urandom();
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [15:0] pick_mask();
    case ($urandom_range(0, 5))
      0: return 16'hffff;
      1: return 16'h0001 << $urandom_range(0, 15);
      2: return '0;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic test_basic_operations();
    send_request(KIND_GET, 3'd0, 4'd0, 16'hffff, '0, '0);           // empty table
    send_request(KIND_DISC, 3'd1, 4'd0, '0, '0, '0);                // nothing held
    send_request(KIND_PUT, 3'd0, 4'd15, '0, 32'hffff_ffff, '0);
    send_request(KIND_PUT, 3'd7, 4'd0, '0, 32'hffff_ffff, '0);
    send_request(KIND_PUT, 3'd2, 4'd0, '0, 32'hffff_ffff, '0);
    send_request(KIND_PUT, 3'd3, 4'd5, '0, '0, '0);
    // Equal priorities: the lower queue wins, then the lower id.
    send_request(KIND_GET, 3'd7, 4'd0, 16'hffff, '0, '0);
    send_request(KIND_GET, 3'd7, 4'd0, 16'hffff, '0, '0);
    send_request(KIND_GET, 3'd6, 4'd0, 16'h7fff, '0, '0);
    send_request(KIND_GET, 3'd6, 4'd0, 16'h0020, '0, '0);
    send_request(KIND_ABORT, 3'd6, 4'd0, '0, '0, 32'd99);           // wrong id
    send_request(KIND_ABORT, 3'd5, 4'd0, '0, '0, 32'd4);            // not the owner
    send_request(KIND_ABORT, 3'd6, 4'd0, '0, '0, 32'd4);
    send_request(KIND_DISC, 3'd7, 4'd0, '0, '0, '0);
    send_request(KIND_DELETE, 3'd0, 4'd0, '0, '0, 32'd1);
    send_request(KIND_DELETE, 3'd0, 4'd0, '0, '0, 32'd1);           // already gone
    send_request(KIND_DELETE, 3'd1, 4'd0, '0, '0, 32'hffff_ffff);
    send_request(KIND_UNUSED_LO, 3'd0, 4'd0, 16'hffff, '0, 32'd2);
    send_request(KIND_UNUSED_MID, 3'd0, 4'd0, 16'hffff, '0, 32'd2);
    send_request(KIND_UNUSED_HI, 3'd7, 4'hf, 16'hffff, 32'hffff_ffff, 32'hffff_ffff);
    send_request(KIND_GET, 3'd4, 4'd0, 16'hffff, '0, '0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < SLOTS + 2; i++)
      send_request(KIND_PUT, i[2:0], i[3:0], '0, pick_priority(), '0);
    send_request(KIND_GET, 3'd2, 4'd0, 16'hffff, '0, '0);
    send_request(KIND_PUT, 3'd1, 4'd3, '0, 32'd7, '0);
    send_request(KIND_PUT, 3'd1, 4'd3, '0, 32'd7, '0);
    for (int i = 0; i < SLOTS; i++)
      send_request(KIND_DELETE, 3'd0, 4'd0, '0, '0, live_job_id());
  endtask

  task automatic test_random_traffic(input int count);
    int          roll;
    int          held;
    logic [2:0]  client;
    logic [31:0] num;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      client = 3'($urandom_range(0, 7));
      held = owned_slot(client);
      num = $urandom();
      if (roll < 32) begin
        send_request(KIND_PUT, client, 4'($urandom()), 16'($urandom()), pick_priority(), num);
      end else if (roll < 62) begin
        send_request(KIND_GET, client, 4'($urandom()), pick_mask(), $urandom(), num);
      end else if (roll < 76) begin
        if ($urandom_range(0, 3) != 0) num = live_job_id();
        send_request(KIND_DELETE, client, 4'($urandom()), 16'($urandom()), $urandom(), num);
      end else if (roll < 88) begin
        if (held >= 0 && $urandom_range(0, 3) != 0) num = job_id[held];
        else if ($urandom_range(0, 1) != 0) num = live_job_id();
        send_request(KIND_ABORT, client, 4'($urandom()), 16'($urandom()), $urandom(), num);
      end else if (roll < 96) begin
        send_request(KIND_DISC, client, 4'($urandom()), 16'($urandom()), $urandom(), num);
      end else begin
        send_request(3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)), client,
                     4'($urandom()), 16'($urandom()), $urandom(), num);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) job_state[i] = ST_FREE;
    next_job_id = 32'd1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_basic_operations();
    test_full_table();
    test_random_traffic(400);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
